@@ src/sird_pkg.sv @@
// ----------------------------------------------------------------------------
// sird_pkg: shared definitions for the signed integer to radix digits block
// Widths, character codes, register indexes, sequencer states and the
// control/status groups between the sequencer and the divide unit.
// ----------------------------------------------------------------------------
package sird_pkg;

  localparam int MAX_BASE    = 16;
  localparam int NUMBER_BITS = 32;

  localparam int MAG_W   = NUMBER_BITS;
  localparam int LEN_W   = $clog2(MAG_W + 1);
  localparam int CNT_W   = $clog2(MAG_W);
  localparam int NDIG_W  = $clog2(MAG_W + 1);
  localparam int BASE_W  = $clog2(MAX_BASE + 1);
  localparam int DIGIT_W = $clog2(MAX_BASE);
  localparam int SHIFT_W = 3;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_HIGH = CFG_IDX_W'(1);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  typedef struct packed {
    logic               last_step;
    logic               quot_zero;
    logic [DIGIT_W-1:0] digit;
  } div_stat_t;

endpackage

@@ src/signed_int_to_radix_digits.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_radix_digits: signed integer to text in a configured radix
// Prints one signed number per command as characters of a digit alphabet.
// ----------------------------------------------------------------------------
// A number is taken when start is high and busy is low. Its characters come
// out one per cycle on character/last_char, marked by strobe, and must be
// taken as they come: a leading '-' for negative values, then the digits
// most significant first, last_char set on the final one. An invalid
// alphabet (shorter than two, holding '+' or '-', or a repeated character)
// gives no beat and the block is ready again in the next cycle. Digits are
// found by a restoring divider that yields one quotient bit per cycle; each
// digit takes one pass over a bound on the running value's bit length (32
// for the first, then fewer by floor(log2 base) per digit, at least 1). A
// new number is not taken until the last character of the previous one is
// out. The alphabet registers may be written only while busy is low.
module signed_int_to_radix_digits (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [sird_pkg::NUMBER_BITS-1:0] number,
  output logic                           strobe,
  output logic [7:0]                     character,
  output logic                           last_char,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sird_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sird_pkg::CFG_W-1:0]     cfg_data
);

  logic [sird_pkg::CFG_W-1:0] alphabet_low;
  logic [sird_pkg::CFG_W-1:0] alphabet_high;

  sird_pkg::state_t state;
  sird_pkg::state_t state_next;

  logic [sird_pkg::DIGIT_W-1:0] stack [sird_pkg::MAG_W];
  logic [sird_pkg::NDIG_W-1:0]  nd;
  logic [sird_pkg::NDIG_W-1:0]  nd_m1;
  logic                         neg;

  logic [2*sird_pkg::CFG_W-1:0] alpha_all;
  logic [7:0]                   abyte [sird_pkg::MAX_BASE];
  logic [sird_pkg::MAX_BASE-1:0] in_alpha;
  logic [sird_pkg::BASE_W-1:0]  radix;
  logic                         bad;
  logic                         base_ok;
  logic [sird_pkg::SHIFT_W-1:0] base_log;

  logic                          accept;
  logic [sird_pkg::MAG_W-1:0]    mag;
  sird_pkg::div_ctrl_t           div_ctrl;
  sird_pkg::div_stat_t           div_stat;
  logic [sird_pkg::DIGIT_W-1:0]  top_digit;

  assign cfg_ready = 1'b1;
  assign alpha_all = {alphabet_high, alphabet_low};

  always_comb begin
    radix = '0;
    bad   = 1'b0;
    for (int i = 0; i < sird_pkg::MAX_BASE; i++) begin
      abyte[i] = alpha_all[8*i +: 8];
    end
    for (int i = 0; i < sird_pkg::MAX_BASE; i++) begin
      if (i == 0) begin
        in_alpha[i] = abyte[i] != 8'h00;
      end else begin
        in_alpha[i] = in_alpha[i-1] && (abyte[i] != 8'h00);
      end
    end
    for (int i = 0; i < sird_pkg::MAX_BASE; i++) begin
      radix = radix + sird_pkg::BASE_W'(in_alpha[i]);
      if (in_alpha[i] && (abyte[i] == sird_pkg::CH_PLUS || abyte[i] == sird_pkg::CH_MINUS)) begin
        bad = 1'b1;
      end
      for (int j = i + 1; j < sird_pkg::MAX_BASE; j++) begin
        if (in_alpha[j] && abyte[i] == abyte[j]) begin
          bad = 1'b1;
        end
      end
    end
    base_ok = (radix >= sird_pkg::BASE_W'(2)) && !bad;
  end

  always_comb begin
    case (radix) inside
      [5'd2:5'd3]:   base_log = sird_pkg::SHIFT_W'(1);
      [5'd4:5'd7]:   base_log = sird_pkg::SHIFT_W'(2);
      [5'd8:5'd15]:  base_log = sird_pkg::SHIFT_W'(3);
      5'd16:         base_log = sird_pkg::SHIFT_W'(4);
      default:       base_log = sird_pkg::SHIFT_W'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_low  <= '0;
      alphabet_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sird_pkg::REG_ALPHABET_LOW:  alphabet_low  <= cfg_data;
        sird_pkg::REG_ALPHABET_HIGH: alphabet_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = start && !busy;
  assign mag    = number[sird_pkg::NUMBER_BITS-1] ? (~number + 1'b1) : number;

  sird_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .mag      (mag),
    .base     (radix),
    .base_log (base_log),
    .stat     (div_stat)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      sird_pkg::ST_IDLE: begin
        if (accept && base_ok) begin
          state_next = sird_pkg::ST_DIV;
        end
      end
      sird_pkg::ST_DIV: begin
        if (div_stat.last_step && div_stat.quot_zero) begin
          state_next = neg ? sird_pkg::ST_SIGN : sird_pkg::ST_EMIT;
        end
      end
      sird_pkg::ST_SIGN: begin
        state_next = sird_pkg::ST_EMIT;
      end
      sird_pkg::ST_EMIT: begin
        if (nd == sird_pkg::NDIG_W'(1)) begin
          state_next = sird_pkg::ST_IDLE;
        end
      end
      default: state_next = sird_pkg::ST_IDLE;
    endcase
  end

  assign nd_m1     = nd - sird_pkg::NDIG_W'(1);
  assign top_digit = stack[nd_m1[sird_pkg::CNT_W-1:0]];

  always_comb begin
    busy          = 1'b1;
    strobe        = 1'b0;
    character     = sird_pkg::CH_MINUS;
    last_char     = 1'b0;
    div_ctrl.load = 1'b0;
    div_ctrl.step = 1'b0;
    unique case (state)
      sird_pkg::ST_IDLE: begin
        busy          = 1'b0;
        div_ctrl.load = accept && base_ok;
      end
      sird_pkg::ST_DIV: begin
        div_ctrl.step = 1'b1;
      end
      sird_pkg::ST_SIGN: begin
        strobe = 1'b1;
      end
      sird_pkg::ST_EMIT: begin
        strobe    = 1'b1;
        character = alpha_all[8*top_digit +: 8];
        last_char = nd == sird_pkg::NDIG_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sird_pkg::ST_IDLE;
      nd    <= '0;
    end else begin
      state <= state_next;
      if (div_ctrl.load) begin
        nd <= '0;
      end else if (div_ctrl.step && div_stat.last_step) begin
        nd <= nd + sird_pkg::NDIG_W'(1);
      end else if (state == sird_pkg::ST_EMIT) begin
        nd <= nd_m1;
      end
    end
  end

  // digit stack and sign: payload, no reset
  always_ff @(posedge clk) begin
    if (div_ctrl.load) begin
      neg <= number[sird_pkg::NUMBER_BITS-1];
    end
    if (div_ctrl.step && div_stat.last_step) begin
      stack[nd[sird_pkg::CNT_W-1:0]] <= div_stat.digit;
    end
  end

endmodule

@@ src/sird_div.sv @@
// ----------------------------------------------------------------------------
// sird_div: iterative divide-by-base unit
// Restoring division, one quotient bit per cycle while step is high, over the
// significant bit length of the running value. At the end of a pass the
// quotient is realigned and the next pass starts on it.
// ----------------------------------------------------------------------------
module sird_div (
  input  logic                        clk,
  input  logic                        rst,
  input  sird_pkg::div_ctrl_t         ctrl,
  input  logic [sird_pkg::MAG_W-1:0]  mag,
  input  logic [sird_pkg::BASE_W-1:0] base,
  input  logic [sird_pkg::SHIFT_W-1:0] base_log,
  output sird_pkg::div_stat_t         stat
);

  logic [sird_pkg::MAG_W-1:0]   dividend;
  logic [sird_pkg::MAG_W-1:0]   dividend_next;
  logic [sird_pkg::DIGIT_W-1:0] rem;
  logic [sird_pkg::DIGIT_W-1:0] rem_next;
  logic [sird_pkg::LEN_W-1:0]   len;
  logic [sird_pkg::LEN_W-1:0]   len_next;
  logic [sird_pkg::CNT_W-1:0]   cnt;

  logic [sird_pkg::BASE_W-1:0]  trial;
  logic [sird_pkg::BASE_W-1:0]  diff;
  logic                         ge;
  logic [sird_pkg::LEN_W-1:0]   shamt;

  always_comb begin
    trial         = {rem, dividend[sird_pkg::MAG_W-1]};
    ge            = trial >= base;
    diff          = trial - base;
    rem_next      = ge ? diff[sird_pkg::DIGIT_W-1:0] : trial[sird_pkg::DIGIT_W-1:0];
    dividend_next = {dividend[sird_pkg::MAG_W-2:0], ge};
    // quotient < 2^(len - floor(log2 base))
    if (len > sird_pkg::LEN_W'(base_log)) begin
      len_next = len - sird_pkg::LEN_W'(base_log);
    end else begin
      len_next = sird_pkg::LEN_W'(1);
    end
    shamt = sird_pkg::LEN_W'(sird_pkg::MAG_W) - len_next;
  end

  assign stat.last_step = cnt == '0;
  assign stat.quot_zero = dividend_next == '0;
  assign stat.digit     = rem_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      len <= '0;
    end else if (ctrl.load) begin
      dividend <= mag;
      rem      <= '0;
      len      <= sird_pkg::LEN_W'(sird_pkg::MAG_W);
      cnt      <= sird_pkg::CNT_W'(sird_pkg::MAG_W - 1);
    end else if (ctrl.step) begin
      if (cnt == '0) begin
        dividend <= dividend_next << shamt[sird_pkg::CNT_W-1:0];
        rem      <= '0;
        len      <= len_next;
        cnt      <= sird_pkg::CNT_W'(len_next - sird_pkg::LEN_W'(1));
      end else begin
        dividend <= dividend_next;
        rem      <= rem_next;
        cnt      <= cnt - sird_pkg::CNT_W'(1);
      end
    end
  end

endmodule
